FILE: rtl/rhp_pkg.sv
// RTP header parser: shared types and constants.
// No dependencies; compile first.
package rhp_pkg;

    localparam int unsigned COUNT_W     = 16;
    localparam int unsigned FIXED_LEN   = 12;
    localparam int unsigned EXT_HDR_LEN = 4;
    localparam int unsigned PARSE_W     = 19;  // fixed + CSRC + ext header + 4 * 65535 words
    localparam logic [1:0]  RTP_VERSION = 2'd2;
    localparam logic [7:0]  P_MASK      = 8'h20;
    localparam logic [7:0]  X_MASK      = 8'h10;
    localparam logic [7:0]  CC_MASK     = 8'h0f;

    typedef enum logic [3:0] {
        ST_OK       = 4'd0,
        ST_SHORT    = 4'd1,
        ST_VERSION  = 4'd2,
        ST_CSRC     = 4'd3,
        ST_EXT_HDR  = 4'd4,
        ST_EXT_BODY = 4'd5,
        ST_PAD_ROOM = 4'd6,
        ST_PAD_ZERO = 4'd7,
        ST_PAD_FIT  = 4'd8,
        ST_OVERSIZE = 4'd9
    } t_status;

    // Header capture state, as seen after the current byte is taken.
    typedef struct packed {
        logic [COUNT_W-1:0] byte_count;
        logic               too_long;
        logic [7:0]         first_byte;
        logic [7:0]         type_byte;
        logic [15:0]        seq;
        logic [31:0]        stamp;
        logic [31:0]        source;
        logic [15:0]        profile;
        logic [15:0]        ext_len;
    } t_hdr;

    typedef struct packed {
        t_status     status;
        logic [7:0]  marker_and_type;
        logic [15:0] seq_number;
        logic [31:0] time_stamp;
        logic [31:0] source_id;
        logic [3:0]  csrc_count;
        logic        extension_present;
        logic [15:0] extension_profile;
        logic [15:0] extension_words;
        logic [15:0] payload_offset;
        logic [15:0] payload_length;
        logic [7:0]  pad_count;
    } t_result;

endpackage

FILE: rtl/rhp_if.sv
// RTP header parser channel interfaces: byte stream in, parse result out.
// Depends on nothing but the valid/ready convention.
interface rhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rhp_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [7:0]  marker_and_type;
    logic [15:0] seq_number;
    logic [31:0] time_stamp;
    logic [31:0] source_id;
    logic [3:0]  csrc_count;
    logic        extension_present;
    logic [15:0] extension_profile;
    logic [15:0] extension_words;
    logic [15:0] payload_offset;
    logic [15:0] payload_length;
    logic [7:0]  pad_count;

    modport source (
        output valid, input ready,
        output status, output marker_and_type, output seq_number,
        output time_stamp, output source_id, output csrc_count,
        output extension_present, output extension_profile, output extension_words,
        output payload_offset, output payload_length, output pad_count
    );
    modport sink (
        input valid, output ready,
        input status, input marker_and_type, input seq_number,
        input time_stamp, input source_id, input csrc_count,
        input extension_present, input extension_profile, input extension_words,
        input payload_offset, input payload_length, input pad_count
    );
endinterface

FILE: rtl/rhp_capture.sv
// Byte counter and positional capture of the RTP fixed and extension header.
// Depends on rhp_pkg.
module rhp_capture #(
    parameter int unsigned MAX_PACKET_BYTES = 65535
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  logic [7:0]    i_data,
    input  logic          i_last,
    output rhp_pkg::t_hdr o_hdr
);
    import rhp_pkg::*;

    localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_PACKET_BYTES);

    t_hdr               r_hdr;
    t_hdr               n_hdr;
    logic [COUNT_W-1:0] w_pos;
    logic [COUNT_W-1:0] w_ext_at;

    assign w_pos    = r_hdr.byte_count;
    // extension header sits right after the CSRC list
    assign w_ext_at = COUNT_W'(FIXED_LEN) + COUNT_W'({r_hdr.first_byte[3:0], 2'b00});

    always_comb begin
        n_hdr = r_hdr;
        if (i_step) begin
            if (r_hdr.byte_count < MAX_CNT) begin
                if (w_pos == COUNT_W'(0)) begin
                    n_hdr.first_byte = i_data;
                end else if (w_pos == COUNT_W'(1)) begin
                    n_hdr.type_byte = i_data;
                end else if (w_pos < COUNT_W'(4)) begin
                    n_hdr.seq = {r_hdr.seq[7:0], i_data};
                end else if (w_pos < COUNT_W'(8)) begin
                    n_hdr.stamp = {r_hdr.stamp[23:0], i_data};
                end else if (w_pos < COUNT_W'(FIXED_LEN)) begin
                    n_hdr.source = {r_hdr.source[23:0], i_data};
                end
                if (w_pos == w_ext_at || w_pos == w_ext_at + COUNT_W'(1)) begin
                    n_hdr.profile = {r_hdr.profile[7:0], i_data};
                end else if (w_pos == w_ext_at + COUNT_W'(2) ||
                             w_pos == w_ext_at + COUNT_W'(3)) begin
                    n_hdr.ext_len = {r_hdr.ext_len[7:0], i_data};
                end
                n_hdr.byte_count = r_hdr.byte_count + COUNT_W'(1);
            end else begin
                // drop the byte, remember the overrun
                n_hdr.too_long = 1'b1;
            end
        end
    end

    assign o_hdr = n_hdr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr <= '0;
        end else if (i_step && i_last) begin
            r_hdr <= '0;
        end else begin
            r_hdr <= n_hdr;
        end
    end

endmodule

FILE: rtl/rhp_check.sv
// Final-byte checks of an RTP packet: status, payload offset, length and padding.
// Depends on rhp_pkg; purely combinational.
module rhp_check (
    input  rhp_pkg::t_hdr    i_hdr,
    input  logic [7:0]       i_last_data,
    output rhp_pkg::t_result o_res
);
    import rhp_pkg::*;

    logic [PARSE_W-1:0] w_len;
    logic [PARSE_W-1:0] w_base;
    logic [PARSE_W-1:0] w_ext_hdr_end;
    logic [PARSE_W-1:0] w_ext_end;
    logic [PARSE_W-1:0] w_parsed;
    logic [PARSE_W-1:0] w_pad_end;
    logic [7:0]         w_pad;
    logic               w_has_p;
    logic               w_has_x;
    t_status            w_status;

    assign w_has_p       = |(i_hdr.first_byte & P_MASK);
    assign w_has_x       = |(i_hdr.first_byte & X_MASK);
    assign w_len         = PARSE_W'(i_hdr.byte_count);
    assign w_base        = PARSE_W'(FIXED_LEN) + PARSE_W'({i_hdr.first_byte[3:0], 2'b00});
    assign w_ext_hdr_end = w_base + PARSE_W'(EXT_HDR_LEN);
    assign w_ext_end     = w_ext_hdr_end + PARSE_W'({i_hdr.ext_len, 2'b00});
    assign w_parsed      = w_has_x ? w_ext_end : w_base;
    assign w_pad         = w_has_p ? i_last_data : 8'd0;
    assign w_pad_end     = w_parsed + PARSE_W'(w_pad);

    always_comb begin
        if (i_hdr.too_long) begin
            w_status = ST_OVERSIZE;
        end else if (w_len < PARSE_W'(FIXED_LEN)) begin
            w_status = ST_SHORT;
        end else if (i_hdr.first_byte[7:6] != RTP_VERSION) begin
            w_status = ST_VERSION;
        end else if (w_base > w_len) begin
            w_status = ST_CSRC;
        end else if (w_has_x && w_ext_hdr_end > w_len) begin
            w_status = ST_EXT_HDR;
        end else if (w_has_x && w_ext_end > w_len) begin
            w_status = ST_EXT_BODY;
        end else if (w_has_p && w_parsed >= w_len) begin
            w_status = ST_PAD_ROOM;
        end else if (w_has_p && w_pad == 8'd0) begin
            w_status = ST_PAD_ZERO;
        end else if (w_has_p && w_pad_end > w_len) begin
            w_status = ST_PAD_FIT;
        end else begin
            w_status = ST_OK;
        end
    end

    always_comb begin
        o_res                 = '0;
        o_res.status          = w_status;
        o_res.marker_and_type = i_hdr.type_byte;
        o_res.seq_number      = i_hdr.seq;
        o_res.time_stamp      = i_hdr.stamp;
        o_res.source_id       = i_hdr.source;
        o_res.csrc_count      = i_hdr.first_byte[3:0] & CC_MASK[3:0];
        if (w_status == ST_OK) begin
            o_res.extension_present = w_has_x;
            o_res.extension_profile = w_has_x ? i_hdr.profile : 16'd0;
            o_res.extension_words   = w_has_x ? i_hdr.ext_len : 16'd0;
            o_res.payload_offset    = w_parsed[15:0];
            o_res.payload_length    = 16'(w_len - w_pad_end);
            o_res.pad_count         = w_pad;
        end
    end

endmodule

FILE: rtl/rtp_header_parser.sv
// RTP header parser top level: input byte register, capture, checks, result register.
// Depends on rhp_pkg, rhp_if, rhp_capture and rhp_check.
//
// Usage:
//   i_in carries the packet one byte per transaction (data_byte), with
//   last_byte high on the final byte. o_res carries one transaction per
//   packet: status, the fixed header fields, the extension header, the
//   payload offset and length and the pad size. The extension, payload
//   and pad fields read as zero when the status is not ok.
//   Throughput: one byte per cycle, across packet boundaries, sustained
//   unless a final byte meets a result the receiver has not yet taken.
//   The final byte is registered in the input register and its result in
//   the result register; capture and checks are combinational between the two.
//   Bytes beyond MAX_PACKET_BYTES are dropped and the packet ends in
//   the oversize status.
//   Reset (synchronous, i_rst_n low) clears the byte counter, the captured
//   header and both valid flags.
//   When the receiver stalls, the result holds and ordinary bytes keep
//   flowing; only a final byte waits in the input register until the
//   result register frees up.
module rtp_header_parser #(
    parameter int unsigned MAX_PACKET_BYTES = 65535
) (
    input logic        i_clk,
    input logic        i_rst_n,
    rhp_in_if.sink     i_in,
    rhp_out_if.source  o_res
);
    import rhp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_data;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;
    logic       w_step;
    t_hdr       w_hdr;
    t_result    w_res;

    // advance the input stage unless a final byte meets a held result
    assign w_step     = r_in_valid && (!r_in_last || !r_out_valid || o_res.ready);
    assign i_in.ready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_data <= i_in.data_byte;
            r_in_last <= i_in.last_byte;
        end
    end

    rhp_capture #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_capture (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_data  (r_in_data),
        .i_last  (r_in_last),
        .o_hdr   (w_hdr)
    );

    rhp_check u_check (
        .i_hdr       (w_hdr),
        .i_last_data (r_in_data),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && r_in_last) begin
            r_out <= w_res;
        end
    end

    assign o_res.valid             = r_out_valid;
    assign o_res.status            = r_out.status;
    assign o_res.marker_and_type   = r_out.marker_and_type;
    assign o_res.seq_number        = r_out.seq_number;
    assign o_res.time_stamp        = r_out.time_stamp;
    assign o_res.source_id         = r_out.source_id;
    assign o_res.csrc_count        = r_out.csrc_count;
    assign o_res.extension_present = r_out.extension_present;
    assign o_res.extension_profile = r_out.extension_profile;
    assign o_res.extension_words   = r_out.extension_words;
    assign o_res.payload_offset    = r_out.payload_offset;
    assign o_res.payload_length    = r_out.payload_length;
    assign o_res.pad_count         = r_out.pad_count;

    a_err_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != ST_OK) |->
            (r_out.payload_offset == 16'd0 && r_out.pad_count == 8'd0 &&
             !r_out.extension_present && r_out.extension_words == 16'd0))
        else $error("error result carries nonzero payload fields");

    a_ok_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_OK) |->
            (r_out.payload_offset >= 16'(FIXED_LEN) && r_out.payload_offset[1:0] == 2'b00))
        else $error("payload offset not a word multiple past the fixed header");

    a_ok_no_ext: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_OK && !r_out.extension_present) |->
            (r_out.extension_profile == 16'd0 && r_out.extension_words == 16'd0))
        else $error("extension fields set without an accepted extension");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_step) |=>
            (r_in_valid && $stable(r_in_data) && $stable(r_in_last)))
        else $error("stalled final byte lost from the input register");

endmodule

FILE: bench/rtp_header_parser_test.sv
`timescale 1ns / 1ps
// Self-checking bench for rtp_header_parser: streams RTP packets byte by byte,
// predicts each parse result and compares it field by field.
// Depends on rhp_pkg, rhp_if and the rtp_header_parser RTL.
module rtp_header_parser_test;
    import rhp_pkg::*;

    localparam int unsigned MAX_BYTES  = 65535;
    localparam int          FILL_RAND  = 0;
    localparam int          FILL_ONES  = 1;
    localparam int          FILL_ZEROS = 2;

    logic i_clk;
    logic i_rst_n;

    rhp_in_if  byte_ch ();
    rhp_out_if result_ch ();

    rtp_header_parser #(
        .MAX_PACKET_BYTES(MAX_BYTES)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_res   (result_ch)
    );

    // Shadow of the parser's capture state.
    int unsigned hdr_count;
    bit          hdr_too_long;
    logic [7:0]  hdr_first;
    logic [7:0]  hdr_type;
    logic [15:0] hdr_seq;
    logic [31:0] hdr_stamp;
    logic [31:0] hdr_source;
    logic [15:0] hdr_profile;
    logic [15:0] hdr_ext_words;

    t_result     expected_results[$];
    logic [7:0]  pkt_bytes[$];
    int          mismatches;
    int          bytes_sent;
    int          results_due;
    int          idle_pct_in;
    int          stall_pct_out;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic void clear_header();
        hdr_count     = 0;
        hdr_too_long  = 1'b0;
        hdr_first     = '0;
        hdr_type      = '0;
        hdr_seq       = '0;
        hdr_stamp     = '0;
        hdr_source    = '0;
        hdr_profile   = '0;
        hdr_ext_words = '0;
    endfunction

    // Take one accepted byte; return 1 with the parse result on the final byte.
    function automatic bit track_byte(input logic [7:0] b, input bit last,
                                      output t_result r);
        int unsigned ext_at;
        int unsigned pos;
        int unsigned len;
        int unsigned parsed;
        int unsigned pad;
        t_status     st;
        bit          ext_ok;
        r = '0;
        if (hdr_count < MAX_BYTES) begin
            pos    = hdr_count;
            ext_at = FIXED_LEN + 4 * int'(hdr_first[3:0]);
            if (pos == 0)
                hdr_first = b;
            else if (pos == 1)
                hdr_type = b;
            else if (pos < 4)
                hdr_seq = {hdr_seq[7:0], b};
            else if (pos < 8)
                hdr_stamp = {hdr_stamp[23:0], b};
            else if (pos < 12)
                hdr_source = {hdr_source[23:0], b};
            if (pos >= ext_at && pos < ext_at + 2)
                hdr_profile = {hdr_profile[7:0], b};
            else if (pos >= ext_at + 2 && pos < ext_at + 4)
                hdr_ext_words = {hdr_ext_words[7:0], b};
            hdr_count++;
        end else begin
            hdr_too_long = 1'b1;
        end
        if (!last)
            return 1'b0;

        len    = hdr_count;
        parsed = FIXED_LEN + 4 * int'(hdr_first[3:0]);
        pad    = 0;
        ext_ok = 1'b0;
        st     = ST_OK;
        if (hdr_too_long) begin
            st = ST_OVERSIZE;
        end else if (len < FIXED_LEN) begin
            st = ST_SHORT;
        end else if (hdr_first[7:6] != RTP_VERSION) begin
            st = ST_VERSION;
        end else if (parsed > len) begin
            st = ST_CSRC;
        end else begin
            if ((hdr_first & X_MASK) != 0) begin
                if (parsed + EXT_HDR_LEN > len) begin
                    st = ST_EXT_HDR;
                end else if (parsed + EXT_HDR_LEN + 4 * int'(hdr_ext_words) > len) begin
                    st = ST_EXT_BODY;
                end else begin
                    parsed += EXT_HDR_LEN + 4 * int'(hdr_ext_words);
                    ext_ok = 1'b1;
                end
            end
            if (st == ST_OK && (hdr_first & P_MASK) != 0) begin
                pad = b;
                if (parsed + 1 > len)
                    st = ST_PAD_ROOM;
                else if (pad == 0)
                    st = ST_PAD_ZERO;
                else if (parsed + pad > len)
                    st = ST_PAD_FIT;
            end
        end

        r.status          = st;
        r.marker_and_type = hdr_type;
        r.seq_number      = hdr_seq;
        r.time_stamp      = hdr_stamp;
        r.source_id       = hdr_source;
        r.csrc_count      = hdr_first[3:0];
        if (st == ST_OK) begin
            r.extension_present = ext_ok;
            r.extension_profile = ext_ok ? hdr_profile : 16'h0;
            r.extension_words   = ext_ok ? hdr_ext_words : 16'h0;
            r.payload_offset    = 16'(parsed);
            r.payload_length    = 16'(len - parsed - pad);
            r.pad_count         = 8'(pad);
        end
        clear_header();
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= 50)
            $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Compare each result transaction with the oldest pending parse.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with none pending", result_ch.status, 0);
            end else begin
                want = expected_results.pop_front();
                check_field("status", result_ch.status, want.status);
                check_field("marker_and_type", result_ch.marker_and_type,
                            want.marker_and_type);
                check_field("seq_number", result_ch.seq_number,
                            want.seq_number);
                check_field("time_stamp", result_ch.time_stamp, want.time_stamp);
                check_field("source_id", result_ch.source_id, want.source_id);
                check_field("csrc_count", result_ch.csrc_count, want.csrc_count);
                check_field("extension_present", result_ch.extension_present,
                            want.extension_present);
                check_field("extension_profile", result_ch.extension_profile,
                            want.extension_profile);
                check_field("extension_words", result_ch.extension_words,
                            want.extension_words);
                check_field("payload_offset", result_ch.payload_offset,
                            want.payload_offset);
                check_field("payload_length", result_ch.payload_length,
                            want.payload_length);
                check_field("pad_count", result_ch.pad_count, want.pad_count);
            end
        end
    end

    // Receiver backpressure.
    always @(negedge i_clk) begin
        result_ch.ready <= ($urandom_range(99) >= stall_pct_out);
    end

    // Call at a falling edge; returns at the falling edge after acceptance.
    task automatic send_byte(input logic [7:0] b, input bit last);
        t_result r;
        while ($urandom_range(99) < idle_pct_in) begin
            byte_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        byte_ch.valid     = 1'b1;
        byte_ch.data_byte = b;
        byte_ch.last_byte = last;
        do
            @(posedge i_clk);
        while (!byte_ch.ready);
        bytes_sent++;
        if (track_byte(b, last, r)) begin
            expected_results.insert(expected_results.size(), r);
            results_due++;
        end
        @(negedge i_clk);
    endtask

    // Hold the byte stream until every pending result has come out.
    task automatic wait_for_results();
        byte_ch.valid = 1'b0;
        while (expected_results.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic pkt_add(input logic [7:0] b);
        pkt_bytes.insert(pkt_bytes.size(), b);
    endtask

    task automatic pkt_header(input logic [7:0] first, input int mode);
        pkt_bytes.delete();
        pkt_add(first);
        repeat (11) begin
            if (mode == FILL_ONES)
                pkt_add(8'hff);
            else if (mode == FILL_ZEROS)
                pkt_add(8'h00);
            else
                pkt_add(8'($urandom_range(255)));
        end
    endtask

    task automatic pkt_fill(input int n);
        repeat (n) pkt_add(8'($urandom_range(255)));
    endtask

    task automatic pkt_trim(input int n);
        while (pkt_bytes.size() > n)
            void'(pkt_bytes.pop_back());
    endtask

    task automatic pkt_send();
        for (int i = 0; i < pkt_bytes.size(); i++)
            send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    endtask

    task automatic set_pressure(input int in_pct, input int out_pct);
        idle_pct_in   = in_pct;
        stall_pct_out = out_pct;
    endtask

    task automatic test_good_headers();
        set_pressure(0, 0);
        pkt_header(8'h80, FILL_ONES);
        pkt_send();
        pkt_header(8'h80, FILL_ZEROS);
        pkt_send();
        pkt_header(8'h7f | 8'h80, FILL_ONES);      // v2, cc 15, no P or X, all ones
        pkt_trim(12);
        pkt_bytes[0] = 8'h8f;
        pkt_fill(60);
        pkt_fill(5);
        pkt_send();
        // X clear: bytes at the extension slot are ordinary payload
        pkt_header(8'h81, FILL_RAND);
        pkt_fill(12);
        pkt_send();
        // CSRC, extension and padding together
        pkt_header(8'hb2, FILL_RAND);
        pkt_fill(8);
        pkt_add(8'hbe);
        pkt_add(8'hde);
        pkt_add(8'h00);
        pkt_add(8'h01);
        pkt_fill(10);
        pkt_add(8'h03);
        pkt_send();
        // padding takes the whole payload
        pkt_header(8'ha0, FILL_RAND);
        pkt_fill(3);
        pkt_add(8'h04);
        pkt_send();
        // empty extension body
        pkt_header(8'h90, FILL_ONES);
        pkt_add(8'hff);
        pkt_add(8'hff);
        pkt_add(8'h00);
        pkt_add(8'h00);
        pkt_send();
        wait_for_results();
    endtask

    task automatic test_error_order();
        set_pressure(0, 0);
        pkt_header(8'h80, FILL_RAND);
        pkt_trim(1);
        pkt_send();
        pkt_header(8'hbf, FILL_ONES);
        pkt_trim(11);
        pkt_send();
        pkt_header(8'h00, FILL_ZEROS);
        pkt_send();
        pkt_header(8'hc0, FILL_ONES);
        pkt_send();
        pkt_header(8'h40, FILL_RAND);
        pkt_fill(4);
        pkt_send();
        pkt_header(8'h8f, FILL_RAND);
        pkt_send();
        pkt_header(8'h90, FILL_RAND);
        pkt_fill(3);
        pkt_send();
        pkt_header(8'h90, FILL_RAND);
        pkt_add(8'hab);
        pkt_add(8'hcd);
        pkt_add(8'h00);
        pkt_add(8'h02);
        pkt_fill(7);
        pkt_send();
        pkt_header(8'h90, FILL_RAND);
        pkt_add(8'h12);
        pkt_add(8'h34);
        pkt_add(8'hff);
        pkt_add(8'hff);
        pkt_fill(8);
        pkt_send();
        // pad byte would sit inside the header
        pkt_header(8'ha0, FILL_RAND);
        pkt_send();
        pkt_header(8'hb0, FILL_RAND);
        pkt_add(8'h55);
        pkt_add(8'haa);
        pkt_add(8'h00);
        pkt_add(8'h00);
        pkt_send();
        pkt_header(8'ha0, FILL_RAND);
        pkt_fill(3);
        pkt_add(8'h00);
        pkt_send();
        pkt_header(8'ha0, FILL_RAND);
        pkt_fill(3);
        pkt_add(8'hff);
        pkt_send();
        wait_for_results();
    endtask

    task automatic test_long_payload();
        set_pressure(0, 0);
        // long payload, then a short packet right behind it
        pkt_header(8'h80, FILL_RAND);
        pkt_fill(40);
        pkt_send();
        pkt_header(8'h80, FILL_RAND);
        pkt_fill(2);
        pkt_send();
        wait_for_results();
    endtask

    task automatic random_packet();
        int          kind;
        int          pad;
        logic [3:0]  cc;
        logic [15:0] words;
        bit          p;
        bit          x;
        kind  = $urandom_range(99);
        cc    = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
        p     = $urandom_range(1);
        x     = $urandom_range(1);
        words = 16'($urandom_range(3));
        pkt_header({2'b10, p, x, cc}, FILL_RAND);
        pkt_fill(4 * cc);
        if (x) begin
            pkt_fill(2);
            pkt_add(words[15:8]);
            pkt_add(words[7:0]);
            pkt_fill(4 * words);
        end
        pkt_fill($urandom_range(24));
        if (p) begin
            pad = $urandom_range(1, 8);
            pkt_fill(pad - 1);
            pkt_add(8'(pad));
        end
        if (kind >= 70) begin
            case ($urandom_range(3))
                0: pkt_trim($urandom_range(1, pkt_bytes.size()));
                1: pkt_bytes[pkt_bytes.size() - 1] = 8'($urandom_range(255));
                2: pkt_bytes[0][7:6] = 2'($urandom_range(3));
                default: begin
                    pkt_bytes.delete();
                    pkt_fill($urandom_range(1, 30));
                end
            endcase
        end
        pkt_send();
    endtask

    task automatic test_random_traffic(input int in_pct, input int out_pct);
        int byte_mark;
        int result_mark;
        set_pressure(in_pct, out_pct);
        byte_mark   = bytes_sent;
        result_mark = results_due;
        while (bytes_sent - byte_mark < 30 || results_due - result_mark < 1) begin
            random_packet();
            if ($urandom_range(9) == 0)
                wait_for_results();
        end
        wait_for_results();
    endtask

    initial begin
        mismatches        = 0;
        bytes_sent        = 0;
        results_due       = 0;
        idle_pct_in       = 0;
        stall_pct_out     = 0;
        i_rst_n           = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.last_byte = 1'b0;
        result_ch.ready   = 1'b0;
        clear_header();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_good_headers();
        test_error_order();
        test_long_payload();
        test_random_traffic(0, 0);
        test_random_traffic(83, 0);
        test_random_traffic(0, 83);
        test_random_traffic(24, 24);

        wait_for_results();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
